>>> rtl/core/rme_pkg.sv
package rme_pkg;

   // Sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_REDUCE = 6'b000010,
      ST_PICK   = 6'b000100,
      ST_MUL    = 6'b001000,
      ST_SQR    = 6'b010000,
      ST_DONE   = 6'b100000
   } rme_state_type;

   // Control broadcast to every slice of the datapath row
   typedef struct packed {
      logic load;     // take load bits into both registers
      logic step;     // take the add / double results
      logic add_en;   // add the multiplicand into the product this step
      logic acc_sub;  // product sum reached the modulus: keep the difference
      logic dbl_sub;  // doubled multiplicand reached the modulus: keep the difference
   } rme_cell_ctl_type;

   // Register indexes
   localparam int unsigned REG_MODULUS = 0;
   localparam int unsigned REG_PUB_EXP = 1;
   localparam int unsigned REG_PRV_EXP = 2;

   // Request mode codes
   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

endpackage

>>> rtl/core/rme_cell.sv
// One bit slice of the modular add / double datapath.
module rme_cell
   import rme_pkg::*;
(
   input  logic             clock,
   input  rme_cell_ctl_type ctl,
   input  logic             m_bit,
   input  logic             ld_acc,
   input  logic             ld_a,
   input  logic             a_lo,     // multiplicand bit of the lower neighbor
   input  logic             c_in,
   output logic             c_out,
   input  logic             bo_in,
   output logic             bo_out,
   input  logic             dbo_in,
   output logic             dbo_out,
   output logic             acc_q,
   output logic             a_q
);

   logic acc_ff, acc_in;
   logic a_ff, a_in;
   logic addend, sum, diff, ddiff;

   // product + multiplicand, then minus modulus
   always_comb begin
      addend  = a_ff & ctl.add_en;
      sum     = acc_ff ^ addend ^ c_in;
      c_out   = (acc_ff & addend) | (c_in & (acc_ff ^ addend));
      diff    = sum ^ m_bit ^ bo_in;
      bo_out  = (~sum & (m_bit | bo_in)) | (m_bit & bo_in);
      // doubled multiplicand is the neighbor's bit, then minus modulus
      ddiff   = a_lo ^ m_bit ^ dbo_in;
      dbo_out = (~a_lo & (m_bit | dbo_in)) | (m_bit & dbo_in);
   end

   always_comb begin
      acc_in = acc_ff;
      a_in   = a_ff;
      if (ctl.load) begin
         acc_in = ld_acc;
         a_in   = ld_a;
      end else if (ctl.step) begin
         acc_in = ctl.acc_sub ? diff : sum;
         a_in   = ctl.dbl_sub ? ddiff : a_lo;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
   end

   assign acc_q = acc_ff;
   assign a_q   = a_ff;

endmodule

>>> rtl/core/rsa_modular_exponentiation.sv
// Channel | Dir | Handshake           | Contents
// req     | in  | req_tvalid/tready   | tdata: value; tuser: mode (1 = decrypt)
// rsp     | out | rsp_tvalid/tready   | tdata: result; tuser: too_large
// csr     | in  | psel/penable/pready | modulus, public and private exponent
//
// One request at a time. Each request runs the base reduction, then a multiply
// for each set exponent bit and a square for each exponent bit shifted out, all on
// the bit-serial row of slices over operands of N = OPERAND_BITS bits.
// An oversized encrypt request or a decrypt with zero modulus skips the computation.
// Synchronous active-high reset clears control and loads modulus 1, exponents 0.
// A new request is taken while the previous response still waits in its register.
module rsa_modular_exponentiation
   import rme_pkg::*;
#(
   parameter int OPERAND_BITS = 31,
   localparam int TDATA_W  = ((OPERAND_BITS + 7) / 8) * 8,
   localparam int CSR_W    = (OPERAND_BITS > 32) ? 64 : 32,
   localparam int ADDR_LSB = (OPERAND_BITS > 32) ? 3 : 2,
   localparam int ADDR_W   = ADDR_LSB + 2
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [TDATA_W-1:0]  req_tdata,   // [OPERAND_BITS-1:0] value
   input  logic                req_tuser,   // [0] mode
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [TDATA_W-1:0]  rsp_tdata,   // [OPERAND_BITS-1:0] result
   output logic                rsp_tuser,   // [0] too_large
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_W-1:0]    csr_pwdata,
   output logic [CSR_W-1:0]    csr_prdata,
   output logic                csr_pready
);

   localparam int N     = OPERAND_BITS;
   localparam int W     = OPERAND_BITS + 1;
   localparam int CNT_W = $clog2(OPERAND_BITS + 1);

   localparam logic [ADDR_W-1:0] ADDR_MODULUS = ADDR_W'(REG_MODULUS << ADDR_LSB);
   localparam logic [ADDR_W-1:0] ADDR_PUB_EXP = ADDR_W'(REG_PUB_EXP << ADDR_LSB);
   localparam logic [ADDR_W-1:0] ADDR_PRV_EXP = ADDR_W'(REG_PRV_EXP << ADDR_LSB);

   rme_state_type state_ff, state_in;
   logic [N-1:0]  mod_ff, pub_ff, prv_ff;
   logic [N-1:0]  v_ff, v_in, e_ff, e_in, b_ff, b_in;
   logic [N-1:0]  base_ff, base_in, res_ff, res_in;
   logic          flag_ff, flag_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff;
   logic [N-1:0]  rsp_res_ff;
   logic          rsp_flag_ff;
   logic          out_load;

   logic [N-1:0]  req_value;
   logic          req_fire, csr_wr;

   rme_cell_ctl_type ctl;
   logic [W-1:0]  ld_acc_vec, ld_a_vec, acc_vec, a_vec, a_lo_vec, m_vec;
   logic [W:0]    carry, bo, dbo;
   logic          shift_in;

   assign req_value = req_tdata[N-1:0];
   assign req_fire  = req_tvalid & req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= N'(1);
         pub_ff <= '0;
         prv_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr)
            ADDR_MODULUS: mod_ff <= csr_pwdata[N-1:0];
            ADDR_PUB_EXP: pub_ff <= csr_pwdata[N-1:0];
            ADDR_PRV_EXP: prv_ff <= csr_pwdata[N-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         ADDR_MODULUS: csr_prdata = CSR_W'(mod_ff);
         ADDR_PUB_EXP: csr_prdata = CSR_W'(pub_ff);
         ADDR_PRV_EXP: csr_prdata = CSR_W'(prv_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // Row of slices
   assign m_vec     = {1'b0, mod_ff};
   assign carry[0]  = 1'b0;
   assign bo[0]     = 1'b0;
   assign dbo[0]    = 1'b0;
   assign a_lo_vec  = {a_vec[W-2:0], shift_in};

   for (genvar i = 0; i < W; i++) begin : g_cell
      rme_cell u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .m_bit   (m_vec[i]),
         .ld_acc  (ld_acc_vec[i]),
         .ld_a    (ld_a_vec[i]),
         .a_lo    (a_lo_vec[i]),
         .c_in    (carry[i]),
         .c_out   (carry[i+1]),
         .bo_in   (bo[i]),
         .bo_out  (bo[i+1]),
         .dbo_in  (dbo[i]),
         .dbo_out (dbo[i+1]),
         .acc_q   (acc_vec[i]),
         .a_q     (a_vec[i])
      );
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      v_in       = v_ff;
      e_in       = e_ff;
      b_in       = b_ff;
      base_in    = base_ff;
      res_in     = res_ff;
      flag_in    = flag_ff;
      cnt_in     = cnt_ff;
      ld_acc_vec = '0;
      ld_a_vec   = '0;
      shift_in   = 1'b0;
      out_load   = 1'b0;
      ctl        = '0;
      ctl.acc_sub = carry[W] | ~bo[W];
      ctl.dbl_sub = a_vec[W-1] | ~dbo[W];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               v_in    = req_value;
               e_in    = (req_tuser == MODE_DECRYPT) ? prv_ff : pub_ff;
               flag_in = 1'b0;
               res_in  = '0;
               if (req_tuser == MODE_ENCRYPT && req_value >= mod_ff) begin
                  flag_in  = 1'b1;
                  state_in = ST_DONE;
               end else if (req_tuser == MODE_DECRYPT && mod_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  ctl.load = 1'b1;
                  cnt_in   = CNT_W'(N);
                  state_in = ST_REDUCE;
               end
            end
         end
         // restoring remainder, value bits MSB first
         ST_REDUCE: begin
            if (cnt_ff != '0) begin
               ctl.step = 1'b1;
               shift_in = v_ff[N-1];
               v_in     = v_ff << 1;
               cnt_in   = cnt_ff - 1'b1;
            end else begin
               base_in  = a_vec[N-1:0];
               res_in   = (mod_ff == N'(1) && e_ff != '0) ? '0 : N'(1);
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (e_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               ctl.load = 1'b1;
               b_in     = base_ff;
               cnt_in   = CNT_W'(N);
               if (e_ff[0]) begin
                  ld_a_vec = {1'b0, res_ff};
                  state_in = ST_MUL;
               end else begin
                  ld_a_vec = {1'b0, base_ff};
                  state_in = ST_SQR;
               end
            end
         end
         ST_MUL, ST_SQR: begin
            if (cnt_ff != '0) begin
               ctl.step   = 1'b1;
               ctl.add_en = b_ff[0];
               b_in       = b_ff >> 1;
               cnt_in     = cnt_ff - 1'b1;
            end else begin
               if (state_ff == ST_MUL) begin
                  res_in = acc_vec[N-1:0];
                  e_in   = {e_ff[N-1:1], 1'b0};
               end else begin
                  base_in = acc_vec[N-1:0];
                  e_in    = e_ff >> 1;
               end
               state_in = ST_PICK;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      e_ff    <= e_in;
      b_ff    <= b_in;
      base_ff <= base_in;
      res_ff  <= res_in;
      flag_ff <= flag_in;
      cnt_ff  <= cnt_in;
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_res_ff  <= res_ff;
         rsp_flag_ff <= flag_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_res_ff);
   assign rsp_tuser  = rsp_flag_ff;

`ifndef SYNTH
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("flagged response carries nonzero result");

   a_op_return: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MUL || state_ff == ST_SQR) && cnt_ff == '0) |=>
      (state_ff == ST_PICK))
      else $error("multiply did not return to exponent scan");
`endif

endmodule

>>> bench/rsa_modular_exponentiation_test.sv
`timescale 1ns / 1ps

module rsa_modular_exponentiation_test;
   import rme_pkg::*;

   localparam int OB      = 31;
   localparam int TDATA_W = 32;
   localparam int ADDR_W  = 4;
   localparam int LIMIT   = 20000;

   typedef struct packed {
      logic [OB-1:0] result;
      logic          too_large;
   } modexp_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata = '0;
   logic               req_tuser = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;
   logic               rsp_tuser;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]  csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   rsa_modular_exponentiation u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   // local copy of the key registers
   logic [OB-1:0] key_modulus  = OB'(1);
   logic [OB-1:0] key_pub_exp  = '0;
   logic [OB-1:0] key_prv_exp  = '0;

   modexp_rsp_type expected_rsps[$];
   int             mismatches = 0;
   int             idle_cycles = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [OB-1:0] mul_mod(logic [OB-1:0] a, logic [OB-1:0] b,
                                             logic [OB-1:0] m);
      logic [63:0] p;
      p = 64'(a) * 64'(b);
      return OB'(p % 64'(m));
   endfunction

   function automatic logic [OB-1:0] pow_mod(logic [OB-1:0] base, logic [OB-1:0] ex,
                                             logic [OB-1:0] m);
      logic [OB-1:0] acc;
      acc = OB'(1);
      base = base % m;
      while (ex != 0) begin
         if (ex[0]) acc = mul_mod(acc % m, base, m);
         base = mul_mod(base, base, m);
         ex = ex >> 1;
      end
      return acc;
   endfunction

   function automatic modexp_rsp_type predict_modexp(logic mode, logic [OB-1:0] v);
      modexp_rsp_type r;
      r = '0;
      if (mode == MODE_ENCRYPT) begin
         if (v >= key_modulus) r.too_large = 1'b1;
         else r.result = pow_mod(v, key_pub_exp, key_modulus);
      end else if (key_modulus != 0) begin
         r.result = pow_mod(v, key_prv_exp, key_modulus);
      end
      return r;
   endfunction

   // result checker with random back-pressure
   initial begin
      modexp_rsp_type want;
      int gap;
      @(negedge reset);
      forever begin
         gap = $urandom_range(0, 3);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_tdata[OB-1:0] !== want.result || rsp_tuser !== want.too_large) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp result %h flag %b, got %h flag %b",
                           want.result, want.too_large, rsp_tdata[OB-1:0], rsp_tuser);
            end
         end
      end
   end

   // valid stays high after an accept when the next request follows at once
   task automatic send_request(logic mode, logic [OB-1:0] v);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_W'(v);
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      expected_rsps.push_back(predict_modexp(mode, v));
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(int unsigned idx, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(idx * 4);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_MODULUS: key_modulus = data[OB-1:0];
         REG_PUB_EXP: key_pub_exp = data[OB-1:0];
         REG_PRV_EXP: key_prv_exp = data[OB-1:0];
         default: ;
      endcase
   endtask

   task automatic set_key(logic [31:0] m, logic [31:0] e, logic [31:0] d);
      wait_drain();
      csr_write(REG_MODULUS, m);
      csr_write(REG_PUB_EXP, e);
      csr_write(REG_PRV_EXP, d);
   endtask

   // reset-value key: modulus 1, exponents 0 gives 1; an encrypt value of 1 or more is flagged too large
   task automatic test_reset_key();
      send_request(MODE_ENCRYPT, 0);
      send_request(MODE_ENCRYPT, 5);
      send_request(MODE_DECRYPT, 31'h7fffffff);
   endtask

   // textbook small key and edge values
   task automatic test_directed();
      set_key(3233, 17, 2753);
      send_request(MODE_ENCRYPT, 65);
      send_request(MODE_DECRYPT, 2790);
      send_request(MODE_ENCRYPT, 3232);
      send_request(MODE_ENCRYPT, 3233);
      send_request(MODE_ENCRYPT, 31'h7fffffff);
      send_request(MODE_DECRYPT, 31'h7fffffff);
      send_request(MODE_DECRYPT, 0);
      set_key(32'hffffffff, 32'hffffffff, 32'h7fffffff);
      send_request(MODE_ENCRYPT, 31'h7ffffffe);
      send_request(MODE_DECRYPT, 31'h7fffffff);
      send_request(MODE_ENCRYPT, 31'h7fffffff);
      // zero modulus
      set_key(0, 5, 7);
      send_request(MODE_ENCRYPT, 0);
      send_request(MODE_DECRYPT, 9);
      // modulus one with zero public exponent
      set_key(1, 0, 3);
      send_request(MODE_ENCRYPT, 0);
      send_request(MODE_DECRYPT, 4);
      // zero exponents
      set_key(31'h5555_5555, 0, 0);
      send_request(MODE_ENCRYPT, 31'h2aaa_aaaa);
      send_request(MODE_DECRYPT, 31'h7fff_ffff);
      // out-of-range register index is ignored
      wait_drain();
      csr_write(3, 32'h1234);
      send_request(MODE_ENCRYPT, 7);
   endtask

   // random keys and values
   task automatic test_random();
      logic [OB-1:0] v;
      logic mode;
      for (int p = 0; p < 9; p++) begin
         set_key(p < 3 ? $urandom_range(2, 1000) : $urandom(), $urandom(), $urandom());
         for (int i = 0; i < 30; i++) begin
            mode = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0) v = OB'($urandom());
            else if (key_modulus != 0) v = OB'($urandom() % key_modulus);
            else v = OB'($urandom());
            send_request(mode, v);
         end
         // after the fifth key, pause until all responses have arrived
         if (p == 4) wait_drain();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_key();
      test_directed();
      test_random();
      wait_drain();
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/rme_pkg.sv
rtl/core/rme_cell.sv
rtl/core/rsa_modular_exponentiation.sv
bench/rsa_modular_exponentiation_test.sv
